// ----- rtl/gbis_pkg.sv -----
// gbis_pkg: shared types and constants for the gray bilinear image scaler
// used by every module under rtl except gbis_frame_store; depends on nothing else
package gbis_pkg;

   localparam int MAX_SRC_W = 1024;
   localparam int MAX_SRC_H = 256;
   localparam int MAX_DST_W = 1024;
   localparam int MAX_DST_H = 256;
   localparam int WGT_BITS  = 11;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_W  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_H  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_W  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_H  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SINGLE = 3'd4;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   typedef struct packed {
      logic       operation;
      logic [9:0] x_pos;
      logic [7:0] y_pos;
      logic [7:0] chan_red;
      logic [7:0] chan_green;
      logic [7:0] chan_blue;
   } req_type;

   typedef struct packed {
      logic [7:0] out_pixel;
      logic [9:0] out_col;
      logic [7:0] out_row;
      logic       bad_coord;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LUMA,
      ST_DIV_X,
      ST_DIV_Y,
      ST_WGT_X,
      ST_WGT_Y,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_RD3,
      ST_HMUL,
      ST_VMUL,
      ST_DONE
   } state_type;

   // control from the sequencer to the divider
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

// ----- rtl/gbis_divider.sv -----
// gbis_divider: radix-2 restoring divider, one quotient bit per cycle
// uses gbis_pkg for its control structs
module gbis_divider import gbis_pkg::*; #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  div_ctl_type      ctl,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output div_sts_type      sts,
   output logic [NUM_W-1:0] quot,
   output logic [DEN_W-1:0] rem
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (ctl.start) begin
         q_in    = num;
         r_in    = '0;
         d_in    = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quot     = q_ff;
   assign rem      = r_ff[DEN_W-1:0];
endmodule

// ----- rtl/gbis_frame_store.sv -----
// gbis_frame_store: single-port gray frame memory with registered read
// standalone, no package needed
module gbis_frame_store #(
   parameter int ADDR_W = 18
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [7:0]        wr_data,
   output logic [7:0]        rd_data
);
   logic [7:0] mem [2**ADDR_W];
   logic [7:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_ff <= mem[addr];
   end

   assign rd_data = rd_ff;
endmodule

// ----- rtl/gray_bilinear_image_scaler.sv -----
// gray_bilinear_image_scaler: top level with sequencer and shared divider
// depends on gbis_pkg, gbis_divider and gbis_frame_store
//
// Usage
//   req_ channel carries load or fetch items (valid/stall); rsp_ returns one
//   result per fetch, loads give none. csr_ is a plain write port; the user
//   must write it only while nothing is in work, the block does not enforce it.
//   A load registers the luma sum on the transfer, then divides it by 1000
//   via reciprocal and writes it to the store (the red channel in single mode).
//   A fetch inside the output size runs six passes of the 26-bit
//   shift-subtract divider (one quotient bit a cycle) for two positions and
//   four weights, with hand-over between them, four reads of the single store
//   port, then multiply and output. A fetch outside the output size skips
//   the divider and goes straight to output.
//   One item is in work at a time; req_stall is high while busy.
//   The result sits in an output register; while rsp_stall is high the
//   block holds it, keeps working and waits only when the next is ready.
//   Reset (synchronous) restores register defaults and empties the
//   sequencer; the frame store is not cleared, unwritten pixels read as
//   garbage. Size registers are saturated to 1..MAX on use.
module gray_bilinear_image_scaler import gbis_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int XA_W   = $clog2(MAX_SRC_W);
   localparam int YA_W   = $clog2(MAX_SRC_H);
   localparam int ADDR_W = XA_W + YA_W;
   localparam int NUM_W  = 26;
   localparam int DEN_W  = 14;
   localparam int H_W    = 8 + WGT_BITS + 2;
   localparam int V_W    = H_W + WGT_BITS + 2;
   localparam logic [WGT_BITS:0] SCALE = (WGT_BITS+1)'(1) << WGT_BITS;

   state_type state_ff, state_in;

   logic [10:0] src_w_ff, dst_w_ff;
   logic [8:0]  src_h_ff, dst_h_ff;
   logic        single_ff;

   req_type     item_ff, item_in;
   rsp_type     out_ff, out_in;
   rsp_type     res_ff, res_in;
   logic        out_v_ff, out_v_in;

   logic [12:0] sw, sh, dw, dh;
   logic [XA_W-1:0] bx_ff, bx_in, bx1;
   logic [YA_W-1:0] by_ff, by_in, by1;
   logic [DEN_W-1:0] remx_ff, remx_in, remy_ff, remy_in;
   logic            clx_ff, clx_in, cly_ff, cly_in;
   logic [WGT_BITS:0] a0_ff, a0_in, a1_ff, a1_in, b0_ff, b0_in, b1_ff, b1_in;
   logic [7:0]  p_ff [4];
   logic [7:0]  p_in [4];
   logic [H_W-1:0] h0_ff, h0_in, h1_ff, h1_in;
   logic [V_W-1:0] v;
   logic [1:0]  sub_ff, sub_in;
   logic [19:0] luma_ff, luma_in;

   div_ctl_type dctl;
   div_sts_type dsts;
   logic [NUM_W-1:0] dnum, dquot;
   logic [DEN_W-1:0] dden, drem;

   logic             mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic [7:0]       mem_wdata, mem_rdata;

   logic signed [26:0] numx, numy;
   logic [13:0] denx, deny;
   logic [31:0] lq;

   function automatic logic [12:0] sat(input logic [10:0] val, input int hi);
      if (val == 11'd0) return 13'd1;
      if (32'(val) > hi) return 13'(hi);
      return {2'b00, val};
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff  <= 11'd200;
         src_h_ff  <= 9'd64;
         dst_w_ff  <= 11'd200;
         dst_h_ff  <= 9'd64;
         single_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SRC_W:  src_w_ff  <= csr_wdata;
            CSR_SRC_H:  src_h_ff  <= csr_wdata[8:0];
            CSR_DST_W:  dst_w_ff  <= csr_wdata;
            CSR_DST_H:  dst_h_ff  <= csr_wdata[8:0];
            CSR_SINGLE: single_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign sw = sat(src_w_ff, MAX_SRC_W);
   assign sh = sat({2'b00, src_h_ff}, MAX_SRC_H);
   assign dw = sat(dst_w_ff, MAX_DST_W);
   assign dh = sat({2'b00, dst_h_ff}, MAX_DST_H);

   // numerator (2x+1)*src - dst, may go negative
   assign numx = $signed({1'b0, 26'({item_ff.x_pos, 1'b1}) * 26'(sw)})
               - $signed({14'd0, dw});
   assign numy = $signed({1'b0, 26'({item_ff.y_pos, 1'b1}) * 26'(sh)})
               - $signed({14'd0, dh});
   assign denx = {dw, 1'b0};
   assign deny = {dh, 1'b0};

   assign bx1 = (13'(bx_ff) + 13'd1 < sw) ? bx_ff + 1'b1 : XA_W'(sw - 13'd1);
   assign by1 = (13'(by_ff) + 13'd1 < sh) ? by_ff + 1'b1 : YA_W'(sh - 13'd1);

   // divide by 1000 via reciprocal: floor(n*4294968/2^32) exact for n < 2^20
   assign lq = 32'((64'(luma_ff) * 64'd4294968) >> 32);

   assign v = V_W'(h0_ff) * V_W'(b0_ff) + V_W'(h1_ff) * V_W'(b1_ff)
            + (V_W'(1) << (2*WGT_BITS - 1));

   gbis_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
      .clock(clock), .reset(reset), .ctl(dctl), .num(dnum), .den(dden),
      .sts(dsts), .quot(dquot), .rem(drem));

   gbis_frame_store #(.ADDR_W(ADDR_W)) u_mem (
      .clock(clock), .wr_en(mem_we), .addr(mem_addr),
      .wr_data(mem_wdata), .rd_data(mem_rdata));

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      out_in    = out_ff;
      res_in    = res_ff;
      out_v_in  = out_v_ff;
      bx_in     = bx_ff;
      by_in     = by_ff;
      remx_in   = remx_ff;
      remy_in   = remy_ff;
      clx_in    = clx_ff;
      cly_in    = cly_ff;
      a0_in     = a0_ff;
      a1_in     = a1_ff;
      b0_in     = b0_ff;
      b1_in     = b1_ff;
      p_in      = p_ff;
      h0_in     = h0_ff;
      h1_in     = h1_ff;
      sub_in    = sub_ff;
      luma_in   = luma_ff;
      dctl.start = 1'b0;
      dnum      = '0;
      dden      = '0;
      mem_we    = 1'b0;
      mem_addr  = {item_ff.y_pos[YA_W-1:0] & YA_W'('1), item_ff.x_pos[XA_W-1:0]};
      mem_wdata = single_ff ? item_ff.chan_red : lq[7:0];
      req_stall = 1'b1;

      if (out_v_ff && !rsp_stall) out_v_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               item_in = req_data;
               if (req_data.operation == OP_LOAD) begin
                  luma_in = 20'(299 * 32'(req_data.chan_red) + 587 * 32'(req_data.chan_green)
                          + 114 * 32'(req_data.chan_blue) + 500);
                  state_in = ST_LUMA;
               end else begin
                  state_in = ST_DIV_X;
                  sub_in   = 2'd0;
               end
            end
         end
         ST_LUMA: begin
            mem_we   = (13'(item_ff.x_pos) < sw) && (13'(item_ff.y_pos) < sh);
            state_in = ST_IDLE;
         end
         ST_DIV_X: begin
            if (13'(item_ff.x_pos) >= dw || 13'(item_ff.y_pos) >= dh) begin
               res_in   = '{out_pixel: 8'd0, out_col: item_ff.x_pos,
                            out_row: item_ff.y_pos, bad_coord: 1'b1};
               state_in = ST_DONE;
            end else if (sub_ff == 2'd0) begin
               dctl.start = 1'b1;
               dnum   = numx[26] ? '0 : NUM_W'(numx);
               dden   = denx;
               sub_in = 2'd1;
            end else if (dsts.done) begin
               clx_in  = numx[26] || (13'(dquot) >= sw - 13'd1) || (dquot >= NUM_W'(sw));
               bx_in   = clx_in ? (numx[26] ? '0 : XA_W'(sw - 13'd1)) : XA_W'(dquot);
               remx_in = drem;
               sub_in  = 2'd0;
               state_in = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (sub_ff == 2'd0) begin
               dctl.start = 1'b1;
               dnum   = numy[26] ? '0 : NUM_W'(numy);
               dden   = deny;
               sub_in = 2'd1;
            end else if (dsts.done) begin
               cly_in  = numy[26] || (dquot >= NUM_W'(sh - 13'd1));
               by_in   = cly_in ? (numy[26] ? '0 : YA_W'(sh - 13'd1)) : YA_W'(dquot);
               remy_in = drem;
               sub_in  = 2'd0;
               state_in = ST_WGT_X;
            end
         end
         ST_WGT_X: begin
            // w1 = floor((2*rem*scale + den) / (2*den))
            if (sub_ff == 2'd0) begin
               dctl.start = 1'b1;
               dnum   = NUM_W'({remx_ff, 1'b0}) * NUM_W'(SCALE) + NUM_W'(denx);
               dden   = DEN_W'({denx, 1'b0});
               sub_in = 2'd1;
            end else if (sub_ff == 2'd1 && dsts.done) begin
               a1_in  = clx_ff ? '0 : (WGT_BITS+1)'(dquot);
               dctl.start = 1'b1;
               dnum   = NUM_W'({DEN_W'(denx - remx_ff), 1'b0}) * NUM_W'(SCALE)
                      + NUM_W'(denx);
               dden   = DEN_W'({denx, 1'b0});
               sub_in = 2'd2;
            end else if (sub_ff == 2'd2 && dsts.done) begin
               a0_in  = clx_ff ? SCALE : (WGT_BITS+1)'(dquot);
               sub_in = 2'd0;
               state_in = ST_WGT_Y;
            end
         end
         ST_WGT_Y: begin
            if (sub_ff == 2'd0) begin
               dctl.start = 1'b1;
               dnum   = NUM_W'({remy_ff, 1'b0}) * NUM_W'(SCALE) + NUM_W'(deny);
               dden   = DEN_W'({deny, 1'b0});
               sub_in = 2'd1;
            end else if (sub_ff == 2'd1 && dsts.done) begin
               b1_in  = cly_ff ? '0 : (WGT_BITS+1)'(dquot);
               dctl.start = 1'b1;
               dnum   = NUM_W'({DEN_W'(deny - remy_ff), 1'b0}) * NUM_W'(SCALE)
                      + NUM_W'(deny);
               dden   = DEN_W'({deny, 1'b0});
               sub_in = 2'd2;
            end else if (sub_ff == 2'd2 && dsts.done) begin
               b0_in  = cly_ff ? SCALE : (WGT_BITS+1)'(dquot);
               sub_in = 2'd0;
               state_in = ST_RD0;
            end
         end
         ST_RD0: begin
            mem_addr = {by_ff, bx_ff};
            state_in = ST_RD1;
         end
         ST_RD1: begin
            mem_addr = {by_ff, bx1};
            p_in[0]  = mem_rdata;
            state_in = ST_RD2;
         end
         ST_RD2: begin
            mem_addr = {by1, bx_ff};
            p_in[1]  = mem_rdata;
            state_in = ST_RD3;
         end
         ST_RD3: begin
            mem_addr = {by1, bx1};
            p_in[2]  = mem_rdata;
            state_in = ST_HMUL;
         end
         ST_HMUL: begin
            p_in[3] = mem_rdata;
            h0_in = H_W'(p_ff[0]) * H_W'(a0_ff) + H_W'(p_ff[1]) * H_W'(a1_ff);
            h1_in = H_W'(p_ff[2]) * H_W'(a0_ff) + H_W'(mem_rdata) * H_W'(a1_ff);
            state_in = ST_VMUL;
         end
         ST_VMUL: begin
            res_in.out_pixel = (v >> (2*WGT_BITS)) > V_W'(255) ? 8'hFF
                             : 8'(v >> (2*WGT_BITS));
            res_in.out_col   = item_ff.x_pos;
            res_in.out_row   = item_ff.y_pos;
            res_in.bad_coord = 1'b0;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // wait here while the previous result is still held
            if (!out_v_ff || !rsp_stall) begin
               out_in   = res_ff;
               out_v_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
         sub_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         sub_ff   <= sub_in;
      end
      item_ff <= item_in;
      out_ff  <= out_in;
      res_ff  <= res_in;
      bx_ff   <= bx_in;
      by_ff   <= by_in;
      remx_ff <= remx_in;
      remy_ff <= remy_in;
      clx_ff  <= clx_in;
      cly_ff  <= cly_in;
      a0_ff   <= a0_in;
      a1_ff   <= a1_in;
      b0_ff   <= b0_in;
      b1_ff   <= b1_in;
      p_ff    <= p_in;
      h0_ff   <= h0_in;
      h1_ff   <= h1_in;
      luma_ff <= luma_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
endmodule

// ----- rtl/gbis_checker.sv -----
// gbis_checker: port-level assertions for the scaler top level
// depends on gbis_pkg; bound to gray_bilinear_image_scaler below
module gbis_checker import gbis_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("new transfer taken while busy");

   a_no_rsp_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared too soon");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_coord |-> rsp_data.out_pixel == 8'd0)
      else $error("bad coordinate with nonzero pixel");
endmodule

bind gray_bilinear_image_scaler gbis_checker u_gbis_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data));

// ----- tb/gray_bilinear_image_scaler_tb.sv -----
// gray_bilinear_image_scaler_tb: self-checking bench for the gray bilinear image scaler
// depends on gbis_pkg and gray_bilinear_image_scaler; predicts each fetch from a local frame copy
`timescale 1ns / 1ps
module gray_bilinear_image_scaler_tb;
   import gbis_pkg::*;

   localparam int FW = 1024;
   localparam int FH = 256;
   localparam int CB = 11;
   localparam int QUIET_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   gray_bilinear_image_scaler dut (.*);

   always #2 clock = ~clock;

   // scaler state mirrored in the bench
   logic [7:0] gray_frame [0:FW*FH-1];
   int unsigned cfg_sw, cfg_sh, cfg_dw, cfg_dh;
   bit cfg_single;

   req_type pending_items[$];
   rsp_type expected_pixels[$];
   int errors = 0;
   int quiet_cycles = 0;
   bit rand_idle = 1'b0;
   bit req_taken = 1'b0;
   int hold_rsp = 0;

   task automatic report(input string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   task automatic queue_item(input req_type it);
      pending_items.insert(pending_items.size(), it);
   endtask

   function automatic int unsigned clip_size(input int unsigned v, input int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic axis_taps(input int unsigned pos, input int unsigned src,
                            input int unsigned dst, output int unsigned base,
                            output longint unsigned w0, output longint unsigned w1);
      longint num, den, b, rem;
      longint unsigned sc;
      sc = 64'd1 << CB;
      num = longint'(2 * pos + 1) * longint'(src) - longint'(dst);
      den = 2 * longint'(dst);
      base = 0; w0 = sc; w1 = 0;
      if (num >= 0) begin
         b = num / den;
         rem = num % den;
         if (b >= longint'(src) - 1) begin
            base = src - 1;
         end else begin
            base = 32'(b);
            w1 = (2 * rem * sc + den) / (2 * den);
            w0 = (2 * (den - rem) * sc + den) / (2 * den);
         end
      end
   endtask

   // apply one accepted item to the mirror, queue the expected pixel of a fetch
   task automatic scale_item(input req_type it);
      int unsigned sw, sh, dw, dh, sx, sy, sx1, sy1, g;
      longint unsigned a0, a1, b0, b1, h0, h1, v;
      rsp_type r;
      sw = clip_size(cfg_sw, FW); sh = clip_size(cfg_sh, FH);
      dw = clip_size(cfg_dw, FW); dh = clip_size(cfg_dh, FH);
      if (it.operation == OP_LOAD) begin
         if (it.x_pos < sw && it.y_pos < sh) begin
            g = cfg_single ? it.chan_red
                : (299 * it.chan_red + 587 * it.chan_green + 114 * it.chan_blue + 500) / 1000;
            gray_frame[it.y_pos * FW + it.x_pos] = g[7:0];
         end
         return;
      end
      r.out_col = it.x_pos;
      r.out_row = it.y_pos;
      if (it.x_pos >= dw || it.y_pos >= dh) begin
         r.out_pixel = 8'd0;
         r.bad_coord = 1'b1;
      end else begin
         axis_taps(it.x_pos, sw, dw, sx, a0, a1);
         axis_taps(it.y_pos, sh, dh, sy, b0, b1);
         sx1 = (sx + 1 < sw) ? sx + 1 : sw - 1;
         sy1 = (sy + 1 < sh) ? sy + 1 : sh - 1;
         h0 = gray_frame[sy * FW + sx] * a0 + gray_frame[sy * FW + sx1] * a1;
         h1 = gray_frame[sy1 * FW + sx] * a0 + gray_frame[sy1 * FW + sx1] * a1;
         v = (h0 * b0 + h1 * b1 + (64'd1 << (2 * CB - 1))) >> (2 * CB);
         r.out_pixel = (v > 255) ? 8'd255 : v[7:0];
         r.bad_coord = 1'b0;
      end
      expected_pixels.insert(expected_pixels.size(), r);
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_items.size() > 0 && !(rand_idle && $urandom_range(99) < 31)) begin
               req_data <= pending_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_rsp > 0) begin
            rsp_stall <= 1'b1;
            hold_rsp <= hold_rsp - 1;
         end else begin
            rsp_stall <= rand_idle && ($urandom_range(99) < 31);
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      rsp_type e;
      req_taken <= req_valid && !req_stall;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (req_valid && !req_stall) begin
            scale_item(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               report("result with nothing expected");
            end else begin
               e = expected_pixels.pop_front();
               if (rsp_data.out_pixel !== e.out_pixel)
                  report($sformatf("pixel %0d expected %0d at (%0d,%0d)", rsp_data.out_pixel,
                                   e.out_pixel, e.out_col, e.out_row));
               if (rsp_data.out_col !== e.out_col)
                  report($sformatf("column %0d expected %0d", rsp_data.out_col, e.out_col));
               if (rsp_data.out_row !== e.out_row)
                  report($sformatf("row %0d expected %0d", rsp_data.out_row, e.out_row));
               if (rsp_data.bad_coord !== e.bad_coord)
                  report($sformatf("bad flag %0d expected %0d at (%0d,%0d)",
                                   rsp_data.bad_coord, e.bad_coord, e.out_col, e.out_row));
            end
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_valid || expected_pixels.size() > 0)
         @(posedge clock);
      // a trailing load may still be in work
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= CSR_DATA_W'(val);
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SRC_W:  cfg_sw = val & 11'h7ff;
         CSR_SRC_H:  cfg_sh = val & 9'h1ff;
         CSR_DST_W:  cfg_dw = val & 11'h7ff;
         CSR_DST_H:  cfg_dh = val & 9'h1ff;
         CSR_SINGLE: cfg_single = val[0];
         default: ;
      endcase
   endtask

   function automatic req_type make_item(input logic op, input int unsigned x,
                                         input int unsigned y);
      req_type it;
      it.operation = op; it.x_pos = 10'(x); it.y_pos = 8'(y);
      it.chan_red = 8'($urandom); it.chan_green = 8'($urandom);
      it.chan_blue = 8'($urandom);
      return it;
   endfunction

   // load the whole working source so no fetch reads an unwritten pixel
   task automatic fill_source();
      int unsigned sw, sh;
      sw = clip_size(cfg_sw, FW); sh = clip_size(cfg_sh, FH);
      for (int y = 0; y < sh; y++)
         for (int x = 0; x < sw; x++)
            queue_item(make_item(OP_LOAD, x, y));
   endtask

   task automatic set_sizes(input int unsigned sw, input int unsigned sh,
                            input int unsigned dw, input int unsigned dh, input bit single);
      csr_write(CSR_SRC_W, sw);
      csr_write(CSR_SRC_H, sh);
      csr_write(CSR_DST_W, dw);
      csr_write(CSR_DST_H, dh);
      csr_write(CSR_SINGLE, single);
   endtask

   task automatic random_fetches(input int n);
      int unsigned dw, dh;
      dw = clip_size(cfg_dw, FW); dh = clip_size(cfg_dh, FH);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0)
            queue_item(make_item(OP_FETCH, $urandom_range(1023), $urandom_range(255)));
         else
            queue_item(make_item(OP_FETCH, $urandom_range(dw - 1), $urandom_range(dh - 1)));
      end
   endtask

   initial begin
      req_type it;
      cfg_sw = 200; cfg_sh = 64; cfg_dw = 200; cfg_dh = 64; cfg_single = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: tiny source, extremes of the channels, outside loads and fetches
      set_sizes(2, 2, 5, 3, 0);
      it = make_item(OP_LOAD, 0, 0); it.chan_red = 255; it.chan_green = 255;
      it.chan_blue = 255; queue_item(it);
      it = make_item(OP_LOAD, 1, 0); it.chan_red = 0; it.chan_green = 0;
      it.chan_blue = 0; queue_item(it);
      queue_item(make_item(OP_LOAD, 0, 1));
      queue_item(make_item(OP_LOAD, 1, 1));
      queue_item(make_item(OP_LOAD, 1023, 255));
      queue_item(make_item(OP_LOAD, 2, 0));
      for (int x = 0; x < 5; x++) queue_item(make_item(OP_FETCH, x, x % 3));
      queue_item(make_item(OP_FETCH, 5, 0));
      queue_item(make_item(OP_FETCH, 0, 3));
      queue_item(make_item(OP_FETCH, 1023, 255));
      wait_drained();

      // downscale, single channel, with the receiver holding off for a long stretch
      set_sizes(9, 7, 3, 2, 1);
      fill_source();
      wait_drained();
      hold_rsp = 400;
      random_fetches(20);
      wait_drained();

      // zero sizes saturate to one
      set_sizes(0, 0, 0, 0, 0);
      fill_source();
      random_fetches(6);
      wait_drained();

      // random phases
      rand_idle = 1'b1;
      for (int p = 0; p < 7; p++) begin
         if (p == 3) rand_idle = 1'b0;
         if (p == 5) rand_idle = 1'b1;
         set_sizes($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(1, 30),
                   $urandom_range(1, 20), $urandom_range(1));
         fill_source();
         random_fetches(60);
         for (int i = 0; i < 10; i++)
            queue_item(make_item(OP_LOAD, $urandom_range(1023), $urandom_range(255)));
         random_fetches(20);
         wait_drained();
      end

      // oversized registers saturate; only the left columns are loaded and fetched
      set_sizes(2047, 2, 1024, 256, 1);
      for (int y = 0; y < 2; y++)
         for (int x = 0; x < 64; x++) queue_item(make_item(OP_LOAD, x, y));
      for (int i = 0; i < 30; i++)
         queue_item(make_item(OP_FETCH, $urandom_range(62), $urandom_range(255)));
      wait_drained();

      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

// ----- gray_bilinear_image_scaler.f -----
rtl/gbis_pkg.sv
rtl/gbis_divider.sv
rtl/gbis_frame_store.sv
rtl/gray_bilinear_image_scaler.sv
rtl/gbis_checker.sv
tb/gray_bilinear_image_scaler_tb.sv
